[hdl/mlrsb_pkg.sv]
// Shared types and constants for the multi-layer ring sample buffer.
// Holds the word formats, operation/status/register codes and control structs.
// No dependencies.
package mlrsb_pkg;

	// Field widths fixed by the word formats
	localparam int OP_W      = 2;
	localparam int LAYER_W   = 3;
	localparam int DATA_W    = 32;
	localparam int REQ_W     = 7;
	localparam int STATUS_W  = 2;
	localparam int CAP_W     = 7;
	localparam int FILL_W    = 7;
	localparam int NUM_REGS  = 4;
	localparam int REG_IDX_W = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_OLDEST = 2'd1;
	localparam logic [OP_W-1:0] OP_NEWEST = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_LAYER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_DATA   = 2'd2;

	// Capacity register indexes
	localparam logic [REG_IDX_W-1:0] REG_BVP   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ACCEL = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_EDA   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_TEMP  = 2'd3;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic [LAYER_W-1:0]       layer;
		logic signed [DATA_W-1:0] sample;
		logic [REQ_W-1:0]         request_count;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample_out;
		logic                     last_of_run;
		logic [STATUS_W-1:0]      status;
		logic [FILL_W-1:0]        layer_fill;
		logic                     all_ready;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;      // load the accepted word into the item register
		logic status_load;  // emit the single status result (and commit a write)
		logic run_start;    // load the read run start index and length
		logic issue;        // read one ring entry
		logic move;         // move read data into the output register
	} mlrsb_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic run_read;   // held item is a read with at least one sample
		logic out_free;   // output register can take a word this cycle
		logic rd_vld;     // read data register holds a sample
		logic left_zero;  // all reads of the run issued
		logic rd_last;    // read data register holds the final sample
	} mlrsb_sts_t;

	// Which capacity register serves a layer
	function automatic reg_idx_t layer_reg(input logic [LAYER_W-1:0] lay);
		reg_idx_t r;
		case (lay) inside
			3'd0:          r = REG_BVP;
			[3'd1:3'd3]:   r = REG_ACCEL;
			3'd4:          r = REG_EDA;
			default:       r = REG_TEMP;
		endcase
		return r;
	endfunction

endpackage

[hdl/mlrsb_ctrl.sv]
// Controller state machine of the multi-layer ring sample buffer.
// Sequences item capture, status results and read runs; uses mlrsb_pkg.
module mlrsb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  mlrsb_pkg::mlrsb_sts_t  sts,
	output mlrsb_pkg::mlrsb_cmd_t  cmd
);
	import mlrsb_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RUN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.run_read) begin
					cmd.run_start = 1'b1;
					state_d       = S_RUN;
				end else if (sts.out_free) begin
					cmd.status_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_RUN: begin
				// advance the read pipe whenever the next stage has room
				cmd.move  = sts.rd_vld && sts.out_free;
				cmd.issue = !sts.left_zero && (!sts.rd_vld || cmd.move);
				if (cmd.move && sts.rd_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/mlrsb_dp.sv]
// Datapath of the multi-layer ring sample buffer: capacity registers, ring
// pointers and fills, sample memory, read pipe and output register. Uses mlrsb_pkg.
module mlrsb_dp #(
	parameter int NUM_LAYERS   = 6,
	parameter int MAX_DEPTH    = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mlrsb_pkg::in_item_t                  in_data,
	input  logic                                 cfg_valid,
	input  logic [mlrsb_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [mlrsb_pkg::CAP_W-1:0]          cfg_data,
	input  mlrsb_pkg::mlrsb_cmd_t                cmd,
	output mlrsb_pkg::mlrsb_sts_t                sts,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output mlrsb_pkg::out_item_t                 out_data
);
	import mlrsb_pkg::*;

	localparam int LAY_W      = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
	localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W      = $clog2(MAX_DEPTH);
	localparam int MEM_DEPTH  = NUM_LAYERS * MAX_DEPTH;
	localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int EXT_W      = (SAMPLE_WIDTH > DATA_W) ? SAMPLE_WIDTH : DATA_W;
	localparam logic [CAP_W-1:0] MAXD_C = CAP_W'(MAX_DEPTH);

	// Configuration and ring state
	logic [CAP_W-1:0]        cap_raw_q [NUM_REGS];
	logic [CNT_W-1:0]        fill_q    [NUM_LAYERS];
	logic [IDX_W-1:0]        pos_q     [NUM_LAYERS];
	logic [SAMPLE_WIDTH-1:0] mem       [MEM_DEPTH];

	// Held item and read run
	in_item_t                item_q;
	logic [IDX_W-1:0]        idx_q;
	logic [CNT_W-1:0]        left_q;
	logic [SAMPLE_WIDTH-1:0] rd_data_s1;
	logic                    rd_vld_s1;
	logic                    rd_last_s1;
	logic                    out_valid_q;
	out_item_t               out_q;

	// Per-layer effective values
	logic [CNT_W-1:0]      cap_eff   [NUM_LAYERS];
	logic [CNT_W-1:0]      fill_eff  [NUM_LAYERS];
	logic [IDX_W-1:0]      pos_eff   [NUM_LAYERS];
	logic [CNT_W-1:0]      fill_post [NUM_LAYERS];
	logic [NUM_LAYERS-1:0] half_ok;
	logic                  all_ready;

	// Selected layer
	logic               bad;
	logic [LAY_W-1:0]   lay_idx;
	logic               is_rd_op;
	logic               wr_upd;
	logic [CNT_W-1:0]   cap_sel;
	logic [CNT_W-1:0]   fill_sel;
	logic [IDX_W-1:0]   pos_sel;
	logic [CNT_W-1:0]   fill_new;
	logic [CNT_W-1:0]   pos_inc;
	logic [IDX_W-1:0]   pos_new;
	logic [CNT_W-1:0]   n_sel;
	logic [CNT_W-1:0]   sub_sel;
	logic [CNT_W:0]     base;
	logic [CNT_W:0]     start_w;
	logic [IDX_W-1:0]   start;
	logic [CNT_W-1:0]   idx_inc;
	logic [IDX_W-1:0]   idx_next;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [SAMPLE_WIDTH-1:0] wr_word;
	logic signed [EXT_W-1:0] ext_in;
	logic signed [EXT_W-1:0] ext_out;
	logic [STATUS_W-1:0]     st_code;
	logic [CNT_W-1:0]        st_fill;

	// Decode the held item
	assign bad      = {1'b0, item_q.layer} >= (LAYER_W + 1)'(NUM_LAYERS);
	assign lay_idx  = bad ? '0 : item_q.layer[LAY_W-1:0];
	assign is_rd_op = (item_q.operation == OP_OLDEST) || (item_q.operation == OP_NEWEST);
	assign wr_upd   = cmd.status_load && !bad && (item_q.operation == OP_WRITE);

	// Clamp capacities, fills and write positions per layer
	for (genvar g = 0; g < NUM_LAYERS; g++) begin : g_layer
		logic [CAP_W-1:0] raw;
		assign raw = cap_raw_q[layer_reg(LAYER_W'(g))];
		assign cap_eff[g] = (raw == '0) ? CNT_W'(1) :
			((raw > MAXD_C) ? CNT_W'(MAX_DEPTH) : CNT_W'(raw));
		assign fill_eff[g] = (fill_q[g] < cap_eff[g]) ? fill_q[g] : cap_eff[g];
		assign pos_eff[g]  = (CNT_W'(pos_q[g]) < cap_eff[g]) ? pos_q[g] : '0;
		assign fill_post[g] = (wr_upd && (lay_idx == LAY_W'(g))) ? fill_new : fill_eff[g];
		assign half_ok[g]  = fill_post[g] >= (cap_eff[g] >> 1);
	end

	assign all_ready = &half_ok;

	assign cap_sel  = cap_eff[lay_idx];
	assign fill_sel = fill_eff[lay_idx];
	assign pos_sel  = pos_eff[lay_idx];

	// Write update: bump position with wrap, saturate fill
	assign fill_new = (fill_sel < cap_sel) ? CNT_W'(fill_sel + 1'b1) : cap_sel;
	assign pos_inc  = CNT_W'(CNT_W'(pos_sel) + 1'b1);
	assign pos_new  = (pos_inc == cap_sel) ? '0 : pos_inc[IDX_W-1:0];

	// Run length and start index
	assign n_sel   = (FILL_W'(fill_sel) < item_q.request_count) ? fill_sel :
		CNT_W'(item_q.request_count);
	assign sub_sel = (item_q.operation == OP_OLDEST) ? fill_sel : n_sel;
	assign base    = (CNT_W + 1)'((CNT_W + 1)'(pos_sel) + (CNT_W + 1)'(cap_sel)
		- (CNT_W + 1)'(sub_sel));
	assign start_w = (base >= (CNT_W + 1)'(cap_sel)) ?
		(CNT_W + 1)'(base - (CNT_W + 1)'(cap_sel)) : base;
	assign start   = start_w[IDX_W-1:0];

	assign idx_inc  = CNT_W'(CNT_W'(idx_q) + 1'b1);
	assign idx_next = (idx_inc == cap_sel) ? '0 : idx_inc[IDX_W-1:0];

	assign wr_addr = ADDR_W'(int'(lay_idx) * MAX_DEPTH + int'(pos_sel));
	assign rd_addr = ADDR_W'(int'(lay_idx) * MAX_DEPTH + int'(idx_q));

	// Sample width conversion in and out
	assign ext_in  = EXT_W'(item_q.sample);
	assign wr_word = ext_in[SAMPLE_WIDTH-1:0];
	assign ext_out = EXT_W'($signed(rd_data_s1));

	// Status result fields
	assign st_code = bad ? ST_BAD_LAYER : (is_rd_op ? ST_NO_DATA : ST_OK);
	assign st_fill = bad ? '0 : ((item_q.operation == OP_WRITE) ? fill_new : fill_sel);

	// Status to controller
	assign sts.run_read  = !bad && is_rd_op && (n_sel != '0);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.rd_vld    = rd_vld_s1;
	assign sts.left_zero = (left_q == '0);
	assign sts.rd_last   = rd_last_s1;

	// Capacity registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cap_raw_q[i] <= CAP_RESET;
			end
		end else if (cfg_valid) begin
			cap_raw_q[cfg_index] <= cfg_data;
		end
	end

	// Ring positions and fills
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LAYERS; i++) begin
				fill_q[i] <= '0;
				pos_q[i]  <= '0;
			end
		end else if (wr_upd) begin
			fill_q[lay_idx] <= fill_new;
			pos_q[lay_idx]  <= pos_new;
		end
	end

	// Sample memory, registered read
	always_ff @(posedge clk) begin
		if (wr_upd) begin
			mem[wr_addr] <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Hold the accepted word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
	end

	// Run counters and read pipe control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			left_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			if (cmd.run_start) begin
				idx_q  <= start;
				left_q <= n_sel;
			end else if (cmd.issue) begin
				idx_q  <= idx_next;
				left_q <= CNT_W'(left_q - 1'b1);
			end
			if (cmd.issue) begin
				rd_vld_s1  <= 1'b1;
				rd_last_s1 <= (left_q == CNT_W'(1));
			end else if (cmd.move) begin
				rd_vld_s1 <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.status_load || cmd.move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.status_load) begin
			out_q.sample_out  <= '0;
			out_q.last_of_run <= 1'b1;
			out_q.status      <= st_code;
			out_q.layer_fill  <= FILL_W'(st_fill);
			out_q.all_ready   <= all_ready;
		end else if (cmd.move) begin
			out_q.sample_out  <= ext_out[DATA_W-1:0];
			out_q.last_of_run <= rd_last_s1;
			out_q.status      <= ST_OK;
			out_q.layer_fill  <= FILL_W'(fill_sel);
			out_q.all_ready   <= all_ready;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hdl/multi_layer_ring_sample_buffer_core.sv]
// Top level of the multi-layer ring sample buffer.
// Joins mlrsb_ctrl and mlrsb_dp; uses mlrsb_pkg.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------
//  in      | in        | in_valid / in_ready  | in_data  (op, layer, sample, count)
//  out     | out       | out_valid / out_ready| out_data (sample, last, status, fill, flag)
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (capacity)
//
// A write, bad layer, empty read or unused operation is taken into the item
// register, then its status result goes into the output register once it is free.
// A read of n samples runs setup, then one memory read per cycle through the
// single read port, paced by the output register.
// Reset clears fills, positions and capacities (to 64); the sample memory is
// not cleared. A stalled output holds the read pipe; configuration is always taken.
module multi_layer_ring_sample_buffer_core #(
	parameter int NUM_LAYERS   = 6,
	parameter int MAX_DEPTH    = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  mlrsb_pkg::in_item_t              in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output mlrsb_pkg::out_item_t             out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mlrsb_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [mlrsb_pkg::CAP_W-1:0]      cfg_data
);
	import mlrsb_pkg::*;

	mlrsb_cmd_t cmd;
	mlrsb_sts_t sts;

	// Capacity writes are always accepted
	assign cfg_ready = 1'b1;

	mlrsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mlrsb_dp #(
		.NUM_LAYERS   (NUM_LAYERS),
		.MAX_DEPTH    (MAX_DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

[verif/multi_layer_ring_sample_buffer_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for multi_layer_ring_sample_buffer_core: sensor words and
// capacity writes go in, every result word is predicted here and compared field by field.
// Depends on mlrsb_pkg and the core RTL only.
module multi_layer_ring_sample_buffer_core_tb;
	import mlrsb_pkg::*;

	localparam int LAYERS      = 6;
	localparam int DEPTH       = 64;
	localparam int RESET_CYC   = 6;
	localparam int TAIL_CYC    = 100;
	localparam int LIMIT_CYC   = 3000000;
	localparam int HOLD_CYC    = 200;
	localparam int MAX_REPORTS = 40;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CAP_W-1:0]     cfg_data  = '0;

	multi_layer_ring_sample_buffer_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Ring state as the predictor sees it
	logic [DATA_W-1:0] ring_mem [LAYERS][DEPTH];
	int                ring_wr_pos [LAYERS];
	int                ring_fill [LAYERS];
	logic [CAP_W-1:0]  cap_regs [NUM_REGS];

	in_item_t  sensor_words_pending [$];
	out_item_t ring_results_due [$];

	bit idling_on      = 1'b1;
	bit word_in_flight = 1'b0;
	int send_gap       = 0;
	int rx_stall       = 0;
	int rx_hold_left   = 0;
	int hold_requests  = 0;
	int holds_served   = 0;

	int words_sent         = 0;
	int results_checked    = 0;
	int capacity_writes    = 0;
	int input_stall_cycles = 0;
	int error_count        = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic reg_idx_t capacity_reg_of(input int lay);
		case (lay)
			0:       return REG_BVP;
			1, 2, 3: return REG_ACCEL;
			4:       return REG_EDA;
			default: return REG_TEMP;
		endcase
	endfunction

	// Map a raw register value onto the ring length actually used
	function automatic int clamp_capacity(input logic [CAP_W-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > DEPTH)
			return DEPTH;
		return int'(raw);
	endfunction

	function automatic int layer_capacity(input int lay);
		return clamp_capacity(cap_regs[capacity_reg_of(lay)]);
	endfunction

	function automatic int layer_level(input int lay);
		int c;
		c = layer_capacity(lay);
		return (ring_fill[lay] < c) ? ring_fill[lay] : c;
	endfunction

	function automatic logic all_layers_half_full();
		for (int i = 0; i < LAYERS; i++)
			if (layer_level(i) < layer_capacity(i) / 2)
				return 1'b0;
		return 1'b1;
	endfunction

	// Advance the ring state by one accepted word and queue the result words it causes
	function automatic void predict_ring_results(input in_item_t w);
		int        lay;
		int        cap;
		int        lvl;
		int        pos;
		int        n;
		int        start;
		out_item_t r;
		lay = int'(w.layer);
		r = '0;
		r.last_of_run = 1'b1;
		if (lay >= LAYERS) begin
			r.status = ST_BAD_LAYER;
			r.all_ready = all_layers_half_full();
			ring_results_due.push_back(r);
			return;
		end
		cap = layer_capacity(lay);
		lvl = layer_level(lay);
		pos = (ring_wr_pos[lay] < cap) ? ring_wr_pos[lay] : 0;
		case (w.operation)
			OP_WRITE: begin
				ring_mem[lay][pos] = w.sample;
				ring_wr_pos[lay] = (pos + 1) % cap;
				ring_fill[lay] = (lvl < cap) ? lvl + 1 : cap;
				r.status = ST_OK;
				r.layer_fill = FILL_W'(ring_fill[lay]);
				r.all_ready = all_layers_half_full();
				ring_results_due.push_back(r);
			end
			OP_OLDEST, OP_NEWEST: begin
				n = (lvl < int'(w.request_count)) ? lvl : int'(w.request_count);
				r.layer_fill = FILL_W'(lvl);
				r.all_ready = all_layers_half_full();
				if (n == 0) begin
					r.status = ST_NO_DATA;
					ring_results_due.push_back(r);
				end else begin
					// oldest window starts at the oldest entry, newest window n back from the head
					if (w.operation == OP_OLDEST)
						start = (pos + cap - lvl) % cap;
					else
						start = (pos + cap - n) % cap;
					r.status = ST_OK;
					for (int i = 0; i < n; i++) begin
						r.sample_out = ring_mem[lay][(start + i) % cap];
						r.last_of_run = (i == n - 1);
						ring_results_due.push_back(r);
					end
				end
			end
			OP_NONE: begin
				r.status = ST_OK;
				r.layer_fill = FILL_W'(lvl);
				r.all_ready = all_layers_half_full();
				ring_results_due.push_back(r);
			end
		endcase
	endfunction

	function automatic void queue_word(input logic [OP_W-1:0] op, input int lay,
		input logic [DATA_W-1:0] smp, input int req);
		in_item_t w;
		w.operation = op;
		w.layer = LAYER_W'(lay);
		w.sample = smp;
		w.request_count = REQ_W'(req);
		sensor_words_pending.push_back(w);
	endfunction

	// Mostly well-formed writes and reads on live layers, some bad layers and unused ops
	function automatic void queue_random_words(input int count);
		int              pick;
		int              lay;
		int              req;
		logic [OP_W-1:0] op;
		logic [DATA_W-1:0] smp;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 8)
				lay = $urandom_range(LAYERS, 7);
			else
				lay = $urandom_range(0, LAYERS - 1);
			if (pick < 45)
				op = OP_WRITE;
			else if (pick < 68)
				op = OP_OLDEST;
			else if (pick < 92)
				op = OP_NEWEST;
			else
				op = OP_NONE;
			case ($urandom_range(0, 9))
				0:       smp = 32'h7FFF_FFFF;
				1:       smp = 32'h8000_0000;
				2:       smp = '0;
				3:       smp = '1;
				default: smp = $urandom();
			endcase
			case ($urandom_range(0, 9))
				0:       req = DEPTH;
				1:       req = $urandom_range(0, 127);
				default: req = $urandom_range(0, layer_capacity(lay) + 2);
			endcase
			queue_word(op, lay, smp, req);
		end
	endfunction

	// Hold off until every queued word is taken and every result word has come back
	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (sensor_words_pending.size() != 0 || word_in_flight ||
			ring_results_due.size() != 0);
	endtask

	task automatic write_capacity(input reg_idx_t idx, input logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cap_regs[idx] = value;
		capacity_writes++;
	endtask

	task automatic set_capacities(input logic [CAP_W-1:0] bvp, accel, eda, temp);
		int old_cap [NUM_REGS];
		wait_until_drained();
		for (int i = 0; i < NUM_REGS; i++)
			old_cap[i] = clamp_capacity(cap_regs[i]);
		write_capacity(REG_BVP, bvp);
		write_capacity(REG_ACCEL, accel);
		write_capacity(REG_EDA, eda);
		write_capacity(REG_TEMP, temp);
		@(negedge clk);
		cfg_valid <= 1'b0;
		// refill every ring that grew, so no read ever reaches a slot never written
		for (int lay = 0; lay < LAYERS; lay++)
			if (layer_capacity(lay) > old_cap[capacity_reg_of(lay)])
				for (int k = 0; k < layer_capacity(lay); k++)
					queue_word(OP_WRITE, lay, $urandom(), 0);
	endtask

	function automatic void check_field(input string field, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: result %0d %s expected %h, got %h", $time, results_checked,
					field, want, got);
		end
	endfunction

	// Feed accepted words to the prediction and pick the gap before the next one
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_ring_results(in_data);
			words_sent++;
			word_in_flight = 1'b0;
			if (idling_on && $urandom_range(0, 5) == 0)
				send_gap = $urandom_range(1, 14);
		end else if (in_valid) begin
			input_stall_cycles++;
		end
	end

	// Offer the next pending word at the falling edge and hold it until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!word_in_flight) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (sensor_words_pending.size() != 0) begin
				in_data <= sensor_words_pending.pop_front();
				in_valid <= 1'b1;
				word_in_flight = 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Drive the result side: long hold-off on request, else random stall bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (holds_served < hold_requests) begin
			holds_served++;
			rx_hold_left = HOLD_CYC;
			out_ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (idling_on && $urandom_range(0, 7) == 0)
				rx_stall = $urandom_range(1, 14);
		end
	end

	// Compare each accepted result word with the oldest one due
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (ring_results_due.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: result word %h with nothing expected", $time, out_data);
			end else begin
				want = ring_results_due.pop_front();
				check_field("sample_out", want.sample_out, out_data.sample_out);
				check_field("last_of_run", want.last_of_run, out_data.last_of_run);
				check_field("status", want.status, out_data.status);
				check_field("layer_fill", want.layer_fill, out_data.layer_fill);
				check_field("all_ready", want.all_ready, out_data.all_ready);
				results_checked++;
			end
		end
	end

	initial begin
		for (int c = 0; c < LIMIT_CYC; c++)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d result words still due", LIMIT_CYC,
			ring_results_due.size());
		$display("multi_layer_ring_sample_buffer_core_tb NOT OK");
		$finish;
	end

	initial begin
		for (int lay = 0; lay < LAYERS; lay++) begin
			ring_wr_pos[lay] = 0;
			ring_fill[lay] = 0;
		end
		for (int i = 0; i < NUM_REGS; i++)
			cap_regs[i] = CAP_RESET;
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty reads, bad layers, unused op, sample extremes, request extremes
		queue_word(OP_OLDEST, 0, '0, 4);
		queue_word(OP_NEWEST, 2, '0, 5);
		queue_word(OP_WRITE, 6, 32'h1234_5678, 0);
		queue_word(OP_OLDEST, 7, '0, 64);
		queue_word(OP_NONE, 1, 32'hDEAD_BEEF, 3);
		queue_word(OP_WRITE, 0, 32'h7FFF_FFFF, 0);
		queue_word(OP_WRITE, 0, 32'h8000_0000, 0);
		queue_word(OP_WRITE, 0, 32'h0000_0000, 0);
		queue_word(OP_WRITE, 0, 32'hFFFF_FFFF, 0);
		queue_word(OP_OLDEST, 0, '0, 0);
		queue_word(OP_OLDEST, 0, '0, 64);
		queue_word(OP_NEWEST, 0, '0, 2);
		queue_word(OP_OLDEST, 0, '0, 127);
		queue_word(OP_NEWEST, 0, '0, 127);
		queue_word(OP_WRITE, 5, 32'h5A5A_5A5A, 0);
		queue_word(OP_WRITE, 4, 32'hA5A5_A5A5, 0);
		queue_word(OP_NEWEST, 5, '0, 1);
		queue_word(OP_NONE, 7, '0, 0);
		queue_word(OP_NONE, 4, '0, 127);
		wait_until_drained();

		// Random traffic, then small and out-of-range capacities, then growth and refills
		queue_random_words(20);
		set_capacities(7'd0, 7'd127, 7'd1, 7'd5);
		queue_random_words(15);
		set_capacities(7'd4, 7'd6, 7'd8, 7'd3);
		hold_requests++;
		queue_random_words(20);
		set_capacities(7'd7, 7'd2, 7'd10, 7'd12);
		idling_on = 1'b0;
		queue_random_words(15);
		wait_until_drained();
		repeat (TAIL_CYC) @(posedge clk);

		$display("Checked %0d result words from %0d sensor words across %0d capacity writes;",
			results_checked, words_sent, capacity_writes);
		$display("offered input words waited %0d cycles in total before being taken.",
			input_stall_cycles);
		if (error_count == 0)
			$display("multi_layer_ring_sample_buffer_core_tb OK");
		else
			$display("multi_layer_ring_sample_buffer_core_tb NOT OK");
		$finish;
	end

endmodule

[files.f]
hdl/mlrsb_pkg.sv
hdl/mlrsb_ctrl.sv
hdl/mlrsb_dp.sv
hdl/multi_layer_ring_sample_buffer_core.sv
verif/multi_layer_ring_sample_buffer_core_tb.sv
